// ----- design/lrct_pkg.sv -----
// shared types, widths and codes for the range cache tracker
package lrct_pkg;

  // field widths fixed by the item layout
  localparam int KEY_W    = 64;
  localparam int TIME_W   = 32;
  localparam int CTR_W    = 32;
  localparam int STATUS_W = 3;
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 4;

  // default directory size
  localparam int DEF_ENTRY_COUNT = 16;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_FAIL  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HOLE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TIMED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TABLE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TEXT  = 3'd4;

  // fetched format codes
  localparam logic [KIND_W-1:0] KIND_TIMED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TABLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TEXT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;    // take the input item into the holding registers
    logic lookup;     // key compare and entry read
    logic eval_go;    // finish a range request
    logic fetch_go;   // finish a fetch result without a victim scan
    logic scan_init;  // start the lru victim scan
    logic scan_step;  // one scan step
    logic alloc_go;   // allocate the scanned victim
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic need_scan;  // fetch result needs an lru victim scan
    logic scan_done;  // all stamps have been read
  } sts_t;

  // stored status for a fetched format
  function automatic logic [STATUS_W-1:0] status_of_kind(input logic [KIND_W-1:0] kind);
    logic [STATUS_W-1:0] st;
    unique case (kind)
      KIND_TIMED: st = ST_TIMED;
      KIND_TABLE: st = ST_TABLE;
      KIND_TEXT:  st = ST_TEXT;
      KIND_SPARE: st = ST_TEXT;
      default:    st = ST_TEXT;
    endcase
    return st;
  endfunction

endpackage

// ----- design/lru_range_cache_tracker.sv -----
// top level of the lru range cache tracker directory
//
//  port group    dir   handshake            payload
//  in_*          in    in_valid / in_stall  op, source_key, range_start, range_end,
//                                           fetch_ok, fetch_kind
//  out_*         out   out_valid / out_stall covered, result_status, fetch_from,
//                                           fetch_to, entry_slot, slot_valid
//
//  a range request does a key compare with entry read, then a span evaluation
//  a fetch result finishes directly, or, when it must allocate and every slot is valid, the
//  lru victim is found by reading one stamp per cycle from the stamp memory
//  one item is in work at a time; the next one enters in the cycle the current one finishes
//  rst_n is synchronous: all slots invalid, use counter at one, nothing pending
//  out_stall holds the result in the output register; work in flight waits only to load it
module lru_range_cache_tracker
  import lrct_pkg::*;
#(
  parameter int ENTRY_COUNT = DEF_ENTRY_COUNT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_op,
  input  logic [KEY_W-1:0]    in_source_key,
  input  logic [TIME_W-1:0]   in_range_start,
  input  logic [TIME_W-1:0]   in_range_end,
  input  logic                in_fetch_ok,
  input  logic [KIND_W-1:0]   in_fetch_kind,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_covered,
  output logic [STATUS_W-1:0] out_result_status,
  output logic [TIME_W-1:0]   out_fetch_from,
  output logic [TIME_W-1:0]   out_fetch_to,
  output logic [SLOT_W-1:0]   out_entry_slot,
  output logic                out_slot_valid
);

  cmd_t cmd;
  sts_t sts;

  // sequencing
  lrct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and result path
  lrct_dpath #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_source_key     (in_source_key),
    .in_range_start    (in_range_start),
    .in_range_end      (in_range_end),
    .in_fetch_ok       (in_fetch_ok),
    .in_fetch_kind     (in_fetch_kind),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_covered       (out_covered),
    .out_result_status (out_result_status),
    .out_fetch_from    (out_fetch_from),
    .out_fetch_to      (out_fetch_to),
    .out_entry_slot    (out_entry_slot),
    .out_slot_valid    (out_slot_valid)
  );

endmodule

// ----- design/lrct_ctrl.sv -----
// controller state machine for the range cache tracker
module lrct_ctrl
  import lrct_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_op,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOOKUP = 6'b000010,
    S_EVAL   = 6'b000100,
    S_FETCH  = 6'b001000,
    S_SCAN   = 6'b010000,
    S_ALLOC  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   done;
  logic   accept;

  // an item finishes when its result can enter the output register
  assign done = ((state_r == S_EVAL) && sts.out_free) ||
                ((state_r == S_FETCH) && !sts.need_scan && sts.out_free) ||
                ((state_r == S_ALLOC) && sts.out_free);

  // the next item may enter in the cycle the current one finishes
  assign in_stall = !((state_r == S_IDLE) || done);
  assign accept   = in_valid && !in_stall;

  // commands
  assign cmd.capture   = accept;
  assign cmd.lookup    = (state_r == S_LOOKUP);
  assign cmd.eval_go   = (state_r == S_EVAL) && sts.out_free;
  assign cmd.fetch_go  = (state_r == S_FETCH) && !sts.need_scan && sts.out_free;
  assign cmd.scan_init = (state_r == S_FETCH) && sts.need_scan;
  assign cmd.scan_step = (state_r == S_SCAN);
  assign cmd.alloc_go  = (state_r == S_ALLOC) && sts.out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    priority if (accept) begin
      state_nxt = in_op ? S_FETCH : S_LOOKUP;
    end else if (done) begin
      state_nxt = S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE:   state_nxt = S_IDLE;
        S_LOOKUP: state_nxt = S_EVAL;
        S_EVAL:   state_nxt = S_EVAL;
        S_FETCH:  state_nxt = sts.need_scan ? S_SCAN : S_FETCH;
        S_SCAN:   state_nxt = sts.scan_done ? S_ALLOC : S_SCAN;
        S_ALLOC:  state_nxt = S_ALLOC;
        default:  state_nxt = S_IDLE;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  // a lookup is always followed by the request evaluation
  a_lookup_then_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOKUP) |=> (state_r == S_EVAL))
    else $error("lookup not followed by evaluation");

  // a finished scan always leads to allocation
  a_scan_then_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && sts.scan_done) |=> (state_r == S_ALLOC))
    else $error("finished scan not followed by allocation");
`endif

endmodule

// ----- design/lrct_dpath.sv -----
// datapath of the range cache tracker: directory storage, lookup, scan and result
module lrct_dpath
  import lrct_pkg::*;
#(
  parameter int ENTRY_COUNT = DEF_ENTRY_COUNT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [KEY_W-1:0]    in_source_key,
  input  logic [TIME_W-1:0]   in_range_start,
  input  logic [TIME_W-1:0]   in_range_end,
  input  logic                in_fetch_ok,
  input  logic [KIND_W-1:0]   in_fetch_kind,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_covered,
  output logic [STATUS_W-1:0] out_result_status,
  output logic [TIME_W-1:0]   out_fetch_from,
  output logic [TIME_W-1:0]   out_fetch_to,
  output logic [SLOT_W-1:0]   out_entry_slot,
  output logic                out_slot_valid
);

  localparam int IW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int CW = $clog2(ENTRY_COUNT + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(ENTRY_COUNT);

  // held input item
  logic [KEY_W-1:0]    key_r;
  logic [TIME_W-1:0]   start_r;
  logic [TIME_W-1:0]   end_r;
  logic                ok_r;
  logic [KIND_W-1:0]   kind_r;

  // directory: valid bits and keys per lane
  logic [ENTRY_COUNT-1:0] valid_r;
  logic [KEY_W-1:0]       key_mem_r [ENTRY_COUNT];

  // directory memories
  logic [CTR_W-1:0]    stamp_mem [ENTRY_COUNT];
  logic [TIME_W-1:0]   old_mem   [ENTRY_COUNT];
  logic [TIME_W-1:0]   young_mem [ENTRY_COUNT];
  logic [STATUS_W-1:0] stat_mem  [ENTRY_COUNT];
  logic [CTR_W-1:0]    stamp_rd_r;
  logic [TIME_W-1:0]   old_rd_r;
  logic [TIME_W-1:0]   young_rd_r;
  logic [STATUS_W-1:0] stat_rd_r;

  // lookup result
  logic                   hit_r;
  logic [IW-1:0]          slot_r;
  logic [ENTRY_COUNT-1:0] match;
  logic [IW-1:0]          match_idx;
  logic [IW-1:0]          free_idx;

  // use counter and pending request
  logic [CTR_W-1:0]    use_ctr_r;
  logic [CTR_W-1:0]    ctr_inc;
  logic                pend_active_r;
  logic                pend_hit_r;
  logic [IW-1:0]       pend_slot_r;
  logic [KEY_W-1:0]    pend_key_r;
  logic [TIME_W-1:0]   pend_start_r;
  logic [TIME_W-1:0]   pend_end_r;
  logic [TIME_W-1:0]   pend_from_r;
  logic [TIME_W-1:0]   pend_to_r;
  logic [TIME_W-1:0]   pend_old_r;
  logic [TIME_W-1:0]   pend_young_r;

  // victim scan
  logic [CW-1:0]       scan_cnt_r;
  logic                cmp_vld_r;
  logic [IW-1:0]       stamp_idx_r;
  logic [IW-1:0]       best_r;
  logic [CTR_W-1:0]    min_r;
  logic                scan_rd;

  // request evaluation
  logic [TIME_W-1:0]   req_from;
  logic [TIME_W-1:0]   req_to;
  logic                req_cov;

  // fetch decisions
  logic [STATUS_W-1:0] kind_st;
  logic                fetch_grow;
  logic                fetch_alloc;
  logic                do_alloc;
  logic [IW-1:0]       alloc_slot;
  logic                touch;
  logic [IW-1:0]       stamp_wa;
  logic                bnd_we;
  logic [IW-1:0]       bnd_wa;
  logic [TIME_W-1:0]   old_wd;
  logic [TIME_W-1:0]   young_wd;
  logic                out_load;

  // result staging
  logic                res_cov;
  logic [STATUS_W-1:0] res_status;
  logic [TIME_W-1:0]   res_from;
  logic [TIME_W-1:0]   res_to;
  logic [SLOT_W-1:0]   res_slot;
  logic                res_sv;

  // capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_r   <= in_source_key;
      start_r <= in_range_start;
      end_r   <= in_range_end;
      ok_r    <= in_fetch_ok;
      kind_r  <= in_fetch_kind;
    end
  end

  // parallel key compare, lowest matching lane and lowest empty lane
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      match[i] = valid_r[i] && (key_mem_r[i] == key_r);
    end
    for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
      if (match[i]) match_idx = IW'(i);
      if (!valid_r[i]) free_idx = IW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_r  <= |match;
      slot_r <= match_idx;
    end
  end

  // missing span of a request
  always_comb begin
    req_from = start_r;
    req_to   = end_r;
    if (hit_r) begin
      req_from = (old_rd_r <= start_r) ? young_rd_r + TIME_W'(1) : start_r;
      req_to   = (young_rd_r >= end_r) ? old_rd_r - TIME_W'(1) : end_r;
    end
    req_cov = hit_r && (req_from > req_to);
  end

  // fetch result decisions
  assign ctr_inc     = use_ctr_r + CTR_W'(1);
  assign kind_st     = status_of_kind(kind_r);
  assign fetch_grow  = cmd.fetch_go && pend_active_r && pend_hit_r;
  assign fetch_alloc = cmd.fetch_go && pend_active_r && !pend_hit_r && ok_r;
  assign do_alloc    = fetch_alloc || cmd.alloc_go;
  assign alloc_slot  = cmd.alloc_go ? best_r : free_idx;
  assign touch       = (cmd.eval_go && hit_r) || fetch_grow || do_alloc;
  assign stamp_wa    = cmd.eval_go ? slot_r : (fetch_grow ? pend_slot_r : alloc_slot);
  assign bnd_we      = fetch_grow || do_alloc;
  assign bnd_wa      = fetch_grow ? pend_slot_r : alloc_slot;
  assign old_wd      = fetch_grow ?
                       ((pend_from_r < pend_old_r) ? pend_from_r : pend_old_r) : pend_start_r;
  assign young_wd    = fetch_grow ?
                       ((pend_to_r > pend_young_r) ? pend_to_r : pend_young_r) : pend_end_r;

  assign sts.need_scan = pend_active_r && !pend_hit_r && ok_r && (&valid_r);
  assign sts.scan_done = (scan_cnt_r == LAST_CNT);

  // use counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_ctr_r <= CTR_W'(1);
    end else if (touch) begin
      use_ctr_r <= ctr_inc;
    end
  end

  // valid bits and keys
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (do_alloc) begin
      valid_r[alloc_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_alloc) begin
      key_mem_r[alloc_slot] <= pend_key_r;
    end
  end

  // stamp memory, read by the scan
  assign scan_rd = cmd.scan_step && (scan_cnt_r != LAST_CNT);

  always_ff @(posedge clk) begin
    if (touch) begin
      stamp_mem[stamp_wa] <= ctr_inc;
    end
    if (scan_rd) begin
      stamp_rd_r <= stamp_mem[scan_cnt_r[IW-1:0]];
    end
  end

  // bounds and status memories, read at lookup
  always_ff @(posedge clk) begin
    if (bnd_we) begin
      old_mem[bnd_wa]   <= old_wd;
      young_mem[bnd_wa] <= young_wd;
    end
    if (do_alloc) begin
      stat_mem[alloc_slot] <= kind_st;
    end
    if (cmd.lookup) begin
      old_rd_r   <= old_mem[match_idx];
      young_rd_r <= young_mem[match_idx];
      stat_rd_r  <= stat_mem[match_idx];
    end
  end

  // pending request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_active_r <= 1'b0;
    end else if (cmd.eval_go) begin
      pend_active_r <= !req_cov;
    end else if (cmd.fetch_go || cmd.alloc_go) begin
      pend_active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval_go && !req_cov) begin
      pend_hit_r   <= hit_r;
      pend_slot_r  <= slot_r;
      pend_key_r   <= key_r;
      pend_start_r <= start_r;
      pend_end_r   <= end_r;
      pend_from_r  <= req_from;
      pend_to_r    <= req_to;
      pend_old_r   <= old_rd_r;
      pend_young_r <= young_rd_r;
    end
  end

  // lru scan: one stamp read per cycle, each stamp compared in the cycle after its read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
      cmp_vld_r  <= 1'b0;
    end else if (cmd.scan_init) begin
      scan_cnt_r <= '0;
      cmp_vld_r  <= 1'b0;
    end else if (cmd.scan_step) begin
      if (scan_rd) begin
        scan_cnt_r <= scan_cnt_r + CW'(1);
      end
      cmp_vld_r <= scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      best_r <= '0;
      min_r  <= use_ctr_r;
    end else if (cmd.scan_step) begin
      if (scan_rd) begin
        stamp_idx_r <= scan_cnt_r[IW-1:0];
      end
      if (cmp_vld_r && (stamp_rd_r != '0) && (stamp_rd_r < min_r)) begin
        min_r  <= stamp_rd_r;
        best_r <= stamp_idx_r;
      end
    end
  end

  // result selection
  always_comb begin
    res_cov    = 1'b0;
    res_status = ST_FAIL;
    res_from   = '0;
    res_to     = '0;
    res_slot   = '0;
    res_sv     = 1'b0;
    priority if (cmd.eval_go) begin
      res_cov    = req_cov;
      res_status = req_cov ? stat_rd_r : ST_FAIL;
      res_from   = req_cov ? '0 : req_from;
      res_to     = req_cov ? '0 : req_to;
      res_slot   = hit_r ? SLOT_W'(slot_r) : '0;
      res_sv     = hit_r;
    end else if (fetch_grow) begin
      res_status = ok_r ? kind_st : ST_HOLE;
      res_slot   = SLOT_W'(pend_slot_r);
      res_sv     = 1'b1;
    end else if (do_alloc) begin
      res_status = kind_st;
      res_slot   = SLOT_W'(alloc_slot);
      res_sv     = 1'b1;
    end else begin
      res_sv     = 1'b0;
    end
  end

  // output register
  assign sts.out_free = !out_valid || !out_stall;
  assign out_load     = cmd.eval_go || cmd.fetch_go || cmd.alloc_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_covered       <= res_cov;
      out_result_status <= res_status;
      out_fetch_from    <= res_from;
      out_fetch_to      <= res_to;
      out_entry_slot    <= res_slot;
      out_slot_valid    <= res_sv;
    end
  end

`ifndef SYNTHESIS
  // allocation without a scan only happens while an empty lane exists
  a_alloc_has_free: assert property (@(posedge clk) disable iff (!rst_n)
    fetch_alloc |-> !(&valid_r))
    else $error("allocation without scan on a full directory");

  // every touch advances the use counter by one
  a_touch_counts: assert property (@(posedge clk) disable iff (!rst_n)
    touch |=> (use_ctr_r == $past(ctr_inc)))
    else $error("use counter did not advance on touch");

  // a result is never loaded over one that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a stalled result");
`endif

endmodule
